FILE: design/swct_pkg.sv
// ----------------------------------------------------------------------------
// swct_pkg
// Shared types and codes for the sequential write capture tracker.
// ----------------------------------------------------------------------------
package swct_pkg;

    localparam int unsigned OFF_W   = 63;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned BYTES_W = 27;
    localparam int unsigned CFG_IDX_W = 3;

    // opcodes
    localparam logic [2:0] OP_OPEN    = 3'd0;
    localparam logic [2:0] OP_WR      = 3'd1;
    localparam logic [2:0] OP_PGWRITE = 3'd2;
    localparam logic [2:0] OP_CLOSE   = 3'd3;
    localparam logic [2:0] OP_CLEANUP = 3'd4;

    // result status codes
    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_OPENED   = 3'd1;
    localparam logic [2:0] ST_ACCEPTED = 3'd2;
    localparam logic [2:0] ST_ABORTED  = 3'd3;
    localparam logic [2:0] ST_LAUNCHED = 3'd4;
    localparam logic [2:0] ST_CLOSED   = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITES_OPT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_PERM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_CAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONN_CAP   = 3'd4;

    localparam logic [BYTES_W-1:0] FILE_CAP_RESET = 27'd4194304;
    localparam logic [BYTES_W-1:0] CONN_CAP_RESET = 27'd16777216;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [7:0]       handle;
        logic             is_write_open;
        logic [OFF_W-1:0] write_offset;
        logic [LEN_W-1:0] payload_length;
        logic             primary_failed;
    } t_req;

    typedef struct packed {
        logic [7:0]         slot_handle;
        logic [2:0]         status;
        logic [BYTES_W-1:0] launch_length;
        logic               cap_drop;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming beat, start the slot read
        logic exec;   // evaluate, update state, register the result
    } t_cmd;

endpackage

FILE: design/swct_in_if.sv
// ----------------------------------------------------------------------------
// swct_in_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface swct_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  handle;
    logic        is_write_open;
    logic [62:0] write_offset;
    logic [31:0] payload_length;
    logic        primary_failed;

    modport source (
        output valid, opcode, handle, is_write_open, write_offset,
               payload_length, primary_failed,
        input  ready
    );
    modport sink (
        input  valid, opcode, handle, is_write_open, write_offset,
               payload_length, primary_failed,
        output ready
    );
endinterface

FILE: design/swct_out_if.sv
// ----------------------------------------------------------------------------
// swct_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface swct_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  slot_handle;
    logic [2:0]  status;
    logic [26:0] launch_length;
    logic        cap_drop;

    modport source (
        output valid, slot_handle, status, launch_length, cap_drop,
        input  ready
    );
    modport sink (
        input  valid, slot_handle, status, launch_length, cap_drop,
        output ready
    );
endinterface

FILE: design/swct_ram.sv
// ----------------------------------------------------------------------------
// swct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/swct_ctrl.sv
// ----------------------------------------------------------------------------
// swct_ctrl
// Sequencer: accept a beat, then evaluate it once the result register is free.
// ----------------------------------------------------------------------------
module swct_ctrl
    import swct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic can_exec;

    assign o_in_ready = (r_state == S_IDLE);
    assign can_exec   = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec  = (r_state == S_EXEC) && can_exec;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (can_exec) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EXEC)
        else $error("accepted beat did not move to evaluation");
    a_exec_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("evaluated beat produced no result");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && r_out_valid && !i_out_ready |=> r_state == S_EXEC)
        else $error("evaluation left while result register full");
`endif
endmodule

FILE: design/swct_dp.sv
// ----------------------------------------------------------------------------
// swct_dp
// Slot table, connection total, configuration and result register.
// ----------------------------------------------------------------------------
module swct_dp
    import swct_pkg::*;
#(
    parameter int unsigned SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  t_req                 i_req,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTES_W-1:0]   i_cfg_data,
    output t_rsp                 o_rsp
);
    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [8:0] SLOTS_N = 9'(SLOTS);
    localparam int unsigned PAD_OFF = OFF_W - BYTES_W;
    localparam int unsigned SUM_W = LEN_W + 1;

    logic r_men, r_wopt, r_wperm;
    logic [BYTES_W-1:0] r_fcap, r_ccap;
    logic [SLOTS-1:0] r_active, n_active;
    logic [SLOTS-1:0] r_aborted, n_aborted;
    logic [BYTES_W-1:0] r_total, n_total;
    t_req r_req;
    t_rsp r_rsp, n_rsp;

    logic [BYTES_W-1:0] ram_q, bytes, free_total;
    logic [IW-1:0] idx;
    logic in_range, gate, act, abt;
    logic [SUM_W-1:0] sum_file, sum_conn;
    logic ram_we;
    logic [BYTES_W-1:0] ram_wdata;

    swct_ram #(.WIDTH(BYTES_W), .DEPTH(SLOTS)) u_bytes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (i_req.handle[IW-1:0]),
        .o_rdata (ram_q)
    );

    assign gate     = r_men && r_wopt && r_wperm;
    assign in_range = {1'b0, r_req.handle} < SLOTS_N;
    assign idx      = r_req.handle[IW-1:0];
    assign act      = in_range && r_active[idx];
    assign abt      = in_range && r_aborted[idx];
    // an inactive slot's RAM word is stale; it reads as empty
    assign bytes    = act ? ram_q : '0;
    assign free_total = (bytes <= r_total) ? (r_total - bytes) : r_total;
    assign sum_file = SUM_W'(bytes) + SUM_W'(r_req.payload_length);
    assign sum_conn = SUM_W'(r_total) + SUM_W'(r_req.payload_length);

    always_comb begin
        n_active  = r_active;
        n_aborted = r_aborted;
        n_total   = r_total;
        ram_we    = 1'b0;
        ram_wdata = '0;
        n_rsp.slot_handle   = r_req.handle;
        n_rsp.status        = ST_IGNORED;
        n_rsp.launch_length = '0;
        n_rsp.cap_drop      = 1'b0;
        if (r_req.opcode == OP_CLEANUP) begin
            n_active  = '0;
            n_aborted = '0;
            n_total   = '0;
            n_rsp.slot_handle = '0;
            n_rsp.status      = ST_CLEARED;
        end else if (gate && in_range) begin
            if (r_req.opcode == OP_OPEN) begin
                if (r_req.is_write_open) begin
                    n_total        = free_total;
                    n_active[idx]  = 1'b1;
                    n_aborted[idx] = 1'b0;
                    ram_we         = 1'b1;
                    n_rsp.status   = ST_OPENED;
                end
            end else if (act) begin
                if (r_req.opcode == OP_PGWRITE) begin
                    n_aborted[idx] = 1'b1;
                    n_rsp.status   = ST_ABORTED;
                end else if (r_req.opcode == OP_WR) begin
                    priority if (abt) begin
                        n_rsp.status = ST_ABORTED;
                    end else if (r_req.primary_failed ||
                                 r_req.write_offset != {{PAD_OFF{1'b0}}, bytes}) begin
                        n_aborted[idx] = 1'b1;
                        n_rsp.status   = ST_ABORTED;
                    end else if (r_req.payload_length == '0) begin
                        n_rsp.status = ST_ACCEPTED;
                    end else if (sum_file > SUM_W'(r_fcap) ||
                                 sum_conn > SUM_W'(r_ccap)) begin
                        n_aborted[idx] = 1'b1;
                        n_rsp.status   = ST_ABORTED;
                        n_rsp.cap_drop = 1'b1;
                    end else begin
                        ram_we       = 1'b1;
                        ram_wdata    = sum_file[BYTES_W-1:0];
                        n_total      = sum_conn[BYTES_W-1:0];
                        n_rsp.status = ST_ACCEPTED;
                    end
                end else if (r_req.opcode == OP_CLOSE) begin
                    if (!abt && bytes != '0 && !r_req.primary_failed) begin
                        n_rsp.status        = ST_LAUNCHED;
                        n_rsp.launch_length = bytes;
                    end else begin
                        n_rsp.status = ST_CLOSED;
                    end
                    n_total        = free_total;
                    n_active[idx]  = 1'b0;
                    n_aborted[idx] = 1'b0;
                end
            end
        end
        if (!i_cmd.exec) ram_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_men     <= 1'b0;
            r_wopt    <= 1'b0;
            r_wperm   <= 1'b0;
            r_fcap    <= FILE_CAP_RESET;
            r_ccap    <= CONN_CAP_RESET;
            r_active  <= '0;
            r_aborted <= '0;
            r_total   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MIRROR_EN:  r_men   <= i_cfg_data[0];
                    REG_WRITES_OPT: r_wopt  <= i_cfg_data[0];
                    REG_WRITE_PERM: r_wperm <= i_cfg_data[0];
                    REG_FILE_CAP:   r_fcap  <= i_cfg_data;
                    REG_CONN_CAP:   r_ccap  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_active  <= n_active;
                r_aborted <= n_aborted;
                r_total   <= n_total;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.exec) r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

`ifndef SYNTHESIS
    a_cleanup_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_req.opcode == OP_CLEANUP |=> r_active == '0 && r_total == '0)
        else $error("cleanup left slots or total behind");
    a_closed_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !gate && r_req.opcode != OP_CLEANUP |=> $stable(r_aborted) &&
            r_rsp.status == ST_IGNORED)
        else $error("closed gate changed a slot");
    a_launch_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && n_rsp.status != ST_LAUNCHED |=> r_rsp.launch_length == '0)
        else $error("launch length set without a launch");
`endif
endmodule

FILE: design/sequential_write_capture_tracker.sv
// ----------------------------------------------------------------------------
// sequential_write_capture_tracker
// Per-handle write capture slot table with file and connection byte caps.
// A request beat is registered while its word is read from the slot byte RAM,
// and is evaluated into the result register once that register is free. No new
// beat is accepted before that evaluation: the read is followed by the write-back.
// Reset (synchronous, active low) clears slot flags, the total and the result
// valid at once and loads default config; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sequential_write_capture_tracker
    import swct_pkg::*;
#(
    parameter int unsigned SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    swct_in_if.sink              i_in,
    swct_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTES_W-1:0]   i_cfg_data
);
    t_cmd cmd;
    t_req req;
    t_rsp rsp;
    logic in_ready, out_valid;

    assign req.opcode         = i_in.opcode;
    assign req.handle         = i_in.handle;
    assign req.is_write_open  = i_in.is_write_open;
    assign req.write_offset   = i_in.write_offset;
    assign req.payload_length = i_in.payload_length;
    assign req.primary_failed = i_in.primary_failed;

    swct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    swct_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (rsp)
    );

    assign i_in.ready          = in_ready;
    assign o_out.valid         = out_valid;
    assign o_out.slot_handle   = rsp.slot_handle;
    assign o_out.status        = rsp.status;
    assign o_out.launch_length = rsp.launch_length;
    assign o_out.cap_drop      = rsp.cap_drop;
endmodule
